FILE: hw/rtl/swmm_pkg.sv
`default_nettype none

package swmm_pkg;

  localparam int unsigned MAX_RADIUS = 10;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;

  // line store ring and horizontal window
  localparam int unsigned RING_ROWS = 2 * MAX_RADIUS + 2;
  localparam int unsigned WIN_TAPS  = 2 * MAX_RADIUS + 1;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned BANK_W = $clog2(RING_ROWS);

  // register field widths
  localparam int unsigned RAD_W      = 4;
  localparam int unsigned WID_W      = 11;
  localparam int unsigned HGT_W      = 13;
  localparam int unsigned CHN_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned PIX_W  = 8;

  // reduction trees are cut into groups, one register between levels
  localparam int unsigned NUM_GRP   = 4;
  localparam int unsigned VGRP_SIZE = (RING_ROWS + NUM_GRP - 1) / NUM_GRP;
  localparam int unsigned HGRP_SIZE = (WIN_TAPS + NUM_GRP - 1) / NUM_GRP;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic OP_PIXEL    = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 3'd0,
    CFG_RADIUS   = 3'd1,
    CFG_WIDTH    = 3'd2,
    CFG_HEIGHT   = 3'd3,
    CFG_CHANNELS = 3'd4
  } cfg_idx_e;

  typedef logic [PIX_W-1:0]     px_t;
  typedef px_t [NUM_CH-1:0]     pix3_t;
  typedef logic [RING_ROWS-1:0] bank_mask_t;

  // one column read of the line stores
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic             col_ok;
    logic             clear;
    logic             emit;
    logic             last;
    bank_mask_t       mask;
  } fetch_t;

  typedef struct packed {
    logic valid;
    logic col_ok;
    logic clear;
    logic emit;
    logic last;
  } stage_t;

  typedef struct packed {
    logic emit;
    logic last;
  } tag_t;

  typedef struct packed {
    pix3_t res;
    logic  frame_end;
  } result_t;

  function automatic px_t px_ext(logic mode, px_t a, px_t b);
    if (mode == MODE_DILATE) begin
      return (a > b) ? a : b;
    end
    return (a < b) ? a : b;
  endfunction

  function automatic px_t px_ident(logic mode);
    return (mode == MODE_DILATE) ? '0 : '1;
  endfunction

  function automatic logic [BANK_W-1:0] bank_inc(logic [BANK_W-1:0] b);
    return (b == BANK_W'(RING_ROWS - 1)) ? '0 : b + BANK_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/square_window_min_max_morphology.sv
`default_nettype none

// Square-window erosion / dilation over a raster pixel stream of up to three
// 8-bit channels. Pixels go into a ring of 2*MAX_RADIUS+2 line-store banks,
// one synchronous RAM per row, all read at the same column in the same cycle.
// A released position's clipped window column is reduced vertically, shifted
// into a 2R+1 tap window and reduced horizontally, through the read, vertical,
// tap and horizontal registers into the output queue. The block takes one
// item per clock; the first result of each output row loads R further columns
// into the tap window, one column read per cycle, and the input stalls
// meanwhile. The input also stalls while 8 results are outstanding (output
// queue depth). Results trail the input by about R rows and R columns; after
// the frame's last pixel, flush items release the rest. A configuration
// write to a defined index restarts the frame and keeps the line stores;
// line store entries are never read before the current frame writes them.
module square_window_min_max_morphology
  import swmm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // pixel / flush items
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  op_i,
  input  wire logic [PIX_W-1:0]      sample_ch0_i,
  input  wire logic [PIX_W-1:0]      sample_ch1_i,
  input  wire logic [PIX_W-1:0]      sample_ch2_i,
  // results
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [PIX_W-1:0]           result_ch0_o,
  output logic [PIX_W-1:0]           result_ch1_o,
  output logic [PIX_W-1:0]           result_ch2_o,
  output logic                       frame_end_o,
  // register writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // configuration; radius, width and height kept already saturated
  // ---------------------------------------------------------------------------
  logic             mode_q;
  logic [RAD_W-1:0] rad_q;
  logic [WID_W-1:0] wid_q;
  logic [HGT_W-1:0] hgt_q;
  logic [CHN_W-1:0] chn_q;

  logic             cfg_we;
  logic             cfg_hit;
  logic [RAD_W-1:0] rad_sat;
  logic [WID_W-1:0] wid_raw, wid_sat;
  logic [HGT_W-1:0] hgt_raw, hgt_sat;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    rad_sat = (cfg_data_i[RAD_W-1:0] > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                          : cfg_data_i[RAD_W-1:0];
    wid_raw = cfg_data_i[WID_W-1:0];
    hgt_raw = cfg_data_i[HGT_W-1:0];
    if (wid_raw == '0) begin
      wid_sat = WID_W'(1);
    end else if (wid_raw > WID_W'(MAX_WIDTH)) begin
      wid_sat = WID_W'(MAX_WIDTH);
    end else begin
      wid_sat = wid_raw;
    end
    if (hgt_raw == '0) begin
      hgt_sat = HGT_W'(1);
    end else if (hgt_raw > HGT_W'(MAX_HEIGHT)) begin
      hgt_sat = HGT_W'(MAX_HEIGHT);
    end else begin
      hgt_sat = hgt_raw;
    end
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_MODE, CFG_RADIUS, CFG_WIDTH, CFG_HEIGHT, CFG_CHANNELS: cfg_hit = 1'b1;
        default:                                                  cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      rad_q  <= '0;
      wid_q  <= WID_W'(MAX_WIDTH);
      hgt_q  <= HGT_W'(1);
      chn_q  <= CHN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_MODE:     mode_q <= cfg_data_i[0];
        CFG_RADIUS:   rad_q  <= rad_sat;
        CFG_WIDTH:    wid_q  <= wid_sat;
        CFG_HEIGHT:   hgt_q  <= hgt_sat;
        CFG_CHANNELS: chn_q  <= cfg_data_i[CHN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WID_W-1:0] wid_m1;
  logic [HGT_W-1:0] hgt_m1;
  px_t              ident;
  pix3_t            ident3;

  assign wid_m1 = wid_q - WID_W'(1);
  assign hgt_m1 = hgt_q - HGT_W'(1);
  assign ident  = px_ident(mode_q);
  assign ident3 = {NUM_CH{ident}};

  // ---------------------------------------------------------------------------
  // frame counters: input position, output position
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [BANK_W-1:0] in_bank_q, in_bank_d, out_bank_q, out_bank_d;
  logic              in_done_q, in_done_d;

  logic              in_acc, is_pix, ready, emit, out_last, restart;
  logic [ROW_W-1:0]  post_row;
  logic [COL_W-1:0]  post_col;
  logic [BANK_W-1:0] post_bank;
  logic              post_done;
  logic [HGT_W-1:0]  need_row, need_row_sum;
  logic [WID_W-1:0]  need_col, need_col_sum;

  logic              pre_busy_q, pre_busy_d;
  logic [RAD_W-1:0]  pre_col_q, pre_col_d;
  bank_mask_t        pre_mask_q, pre_mask_d;
  logic              pre_last_q, pre_last_d;
  logic [FIFO_CNT_W-1:0] pend_q, pend_d;

  assign in_stall_o = pre_busy_q || (pend_q >= FIFO_CNT_W'(FIFO_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_pix     = in_acc && (op_i == OP_PIXEL) && !in_done_q;

  always_comb begin
    post_row  = in_row_q;
    post_col  = in_col_q;
    post_bank = in_bank_q;
    post_done = in_done_q;
    if (is_pix) begin
      if ({1'b0, in_col_q} == wid_m1) begin
        post_col = '0;
        if ({1'b0, in_row_q} == hgt_m1) begin
          post_row  = '0;
          post_bank = '0;
          post_done = 1'b1;
        end else begin
          post_row  = in_row_q + ROW_W'(1);
          post_bank = bank_inc(in_bank_q);
        end
      end else begin
        post_col = in_col_q + COL_W'(1);
      end
    end
  end

  // last input position a result at the output position depends on
  always_comb begin
    need_row_sum = {1'b0, out_row_q} + HGT_W'(rad_q);
    need_row     = (need_row_sum > hgt_m1) ? hgt_m1 : need_row_sum;
    need_col_sum = {1'b0, out_col_q} + WID_W'(rad_q);
    need_col     = (need_col_sum > wid_m1) ? wid_m1 : need_col_sum;
    ready = post_done
         || ({1'b0, post_row} > need_row)
         || (({1'b0, post_row} == need_row) && ({1'b0, post_col} > need_col));
  end

  assign emit     = in_acc && ready;
  assign out_last = ({1'b0, out_row_q} == hgt_m1) && ({1'b0, out_col_q} == wid_m1);
  assign restart  = cfg_hit || (emit && out_last);

  always_comb begin
    in_row_d   = post_row;
    in_col_d   = post_col;
    in_bank_d  = post_bank;
    in_done_d  = post_done;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_bank_d = out_bank_q;
    if (emit) begin
      if ({1'b0, out_col_q} == wid_m1) begin
        out_col_d  = '0;
        out_row_d  = out_row_q + ROW_W'(1);
        out_bank_d = bank_inc(out_bank_q);
      end else begin
        out_col_d = out_col_q + COL_W'(1);
      end
    end
    if (restart) begin
      in_row_d   = '0;
      in_col_d   = '0;
      in_bank_d  = '0;
      in_done_d  = 1'b0;
      out_row_d  = '0;
      out_col_d  = '0;
      out_bank_d = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // window rows -> bank mask
  // ---------------------------------------------------------------------------
  logic [RAD_W-1:0]  d_top;
  logic [ROW_W-1:0]  top_row;
  logic [HGT_W-1:0]  span_full;
  logic [BANK_W-1:0] span, top_bank;
  bank_mask_t        win_mask;

  always_comb begin
    logic [BANK_W:0] bidx;
    logic [BANK_W:0] bank_dist;
    d_top     = (out_row_q > ROW_W'(rad_q)) ? rad_q : out_row_q[RAD_W-1:0];
    top_row   = out_row_q - ROW_W'(d_top);
    span_full = need_row - {1'b0, top_row};
    span      = span_full[BANK_W-1:0];
    if (out_bank_q >= BANK_W'(d_top)) begin
      top_bank = out_bank_q - BANK_W'(d_top);
    end else begin
      top_bank = BANK_W'({1'b0, out_bank_q} + (BANK_W+1)'(RING_ROWS) - (BANK_W+1)'(d_top));
    end
    for (int b = 0; b < RING_ROWS; b++) begin
      bidx = (BANK_W+1)'(b);
      if (bidx >= {1'b0, top_bank}) begin
        bank_dist = bidx - {1'b0, top_bank};
      end else begin
        bank_dist = bidx + (BANK_W+1)'(RING_ROWS) - {1'b0, top_bank};
      end
      win_mask[b] = (bank_dist <= {1'b0, span});
    end
  end

  // ---------------------------------------------------------------------------
  // column read sequencing; row start loads columns 0..R
  // ---------------------------------------------------------------------------
  fetch_t           fetch_d;
  logic [WID_W-1:0] col_sum;

  always_comb begin
    fetch_d    = '0;
    col_sum    = {1'b0, out_col_q} + WID_W'(rad_q);
    pre_busy_d = pre_busy_q;
    pre_col_d  = pre_col_q;
    pre_mask_d = pre_mask_q;
    pre_last_d = pre_last_q;
    if (pre_busy_q) begin
      fetch_d.valid  = 1'b1;
      fetch_d.col    = COL_W'(pre_col_q);
      fetch_d.col_ok = (WID_W'(pre_col_q) < wid_q);
      fetch_d.emit   = (pre_col_q == rad_q);
      fetch_d.last   = pre_last_q;
      fetch_d.mask   = pre_mask_q;
      pre_busy_d     = (pre_col_q != rad_q);
      pre_col_d      = pre_col_q + RAD_W'(1);
    end else if (emit) begin
      fetch_d.valid = 1'b1;
      fetch_d.last  = out_last;
      fetch_d.mask  = win_mask;
      if (out_col_q == '0) begin
        fetch_d.col    = '0;
        fetch_d.col_ok = 1'b1;
        fetch_d.clear  = 1'b1;
        fetch_d.emit   = (rad_q == '0);
        pre_busy_d     = (rad_q != '0);
        pre_col_d      = RAD_W'(1);
        pre_mask_d     = win_mask;
        pre_last_d     = out_last;
      end else begin
        fetch_d.col    = col_sum[COL_W-1:0];
        fetch_d.col_ok = (col_sum <= wid_m1);
        fetch_d.emit   = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // line store banks
  // ---------------------------------------------------------------------------
  logic              wr_en;
  logic [BANK_W-1:0] wr_bank;
  logic [COL_W-1:0]  wr_col;
  pix3_t             wr_data;
  pix3_t             rd_data_q [RING_ROWS];
  logic [RING_ROWS-1:0] fwd_q;
  pix3_t             fwd_data_q;
  pix3_t             rd_pix [RING_ROWS];

  assign wr_en   = is_pix;
  assign wr_bank = in_bank_q;
  assign wr_col  = in_col_q;
  assign wr_data = {sample_ch2_i, sample_ch1_i, sample_ch0_i};

  for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
    pix3_t mem [MAX_WIDTH];

    always_ff @(posedge clk_i) begin
      if (wr_en && (wr_bank == BANK_W'(b))) begin
        mem[wr_col] <= wr_data;
      end
      rd_data_q[b] <= mem[fetch_d.col];
    end

    // the releasing item's own pixel is written at the same edge
    always_ff @(posedge clk_i) begin
      fwd_q[b] <= wr_en && (wr_bank == BANK_W'(b)) && (wr_col == fetch_d.col);
    end

    assign rd_pix[b] = fwd_q[b] ? fwd_data_q : rd_data_q[b];
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
  end

  // ---------------------------------------------------------------------------
  // vertical reduction, two levels
  // ---------------------------------------------------------------------------
  fetch_t s1_q;
  stage_t s2_q;
  pix3_t  vgrp_d [NUM_GRP];
  pix3_t  vgrp_q [NUM_GRP];
  pix3_t  vcol;

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        vgrp_d[g][c] = ident;
        for (int i = 0; i < VGRP_SIZE; i++) begin
          if (g * VGRP_SIZE + i < RING_ROWS) begin
            if (s1_q.mask[g * VGRP_SIZE + i]) begin
              vgrp_d[g][c] = px_ext(mode_q, vgrp_d[g][c], rd_pix[g * VGRP_SIZE + i][c]);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vgrp_q <= vgrp_d;
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      vcol[c] = ident;
      for (int g = 0; g < NUM_GRP; g++) begin
        vcol[c] = px_ext(mode_q, vcol[c], vgrp_q[g][c]);
      end
    end
    if (!s2_q.col_ok) begin
      vcol = ident3;
    end
  end

  // ---------------------------------------------------------------------------
  // horizontal tap window; tap k holds column ox+R-k
  // ---------------------------------------------------------------------------
  pix3_t taps_q [WIN_TAPS];
  tag_t  s3_q, s4_q;
  pix3_t hgrp_d [NUM_GRP];
  pix3_t hgrp_q [NUM_GRP];

  always_ff @(posedge clk_i) begin
    if (s2_q.valid) begin
      taps_q[0] <= vcol;
      for (int k = 1; k < WIN_TAPS; k++) begin
        taps_q[k] <= s2_q.clear ? ident3 : taps_q[k-1];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        hgrp_d[g][c] = ident;
        for (int i = 0; i < HGRP_SIZE; i++) begin
          if ((g * HGRP_SIZE + i < WIN_TAPS) && (g * HGRP_SIZE + i <= 2 * int'(rad_q))) begin
            hgrp_d[g][c] = px_ext(mode_q, hgrp_d[g][c], taps_q[g * HGRP_SIZE + i][c]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hgrp_q <= hgrp_d;
  end

  result_t res_d;

  always_comb begin
    res_d = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      res_d.res[c] = ident;
      for (int g = 0; g < NUM_GRP; g++) begin
        res_d.res[c] = px_ext(mode_q, res_d.res[c], hgrp_q[g][c]);
      end
      if (CHN_W'(c) >= chn_q) begin
        res_d.res[c] = '0;
      end
    end
    res_d.frame_end = s4_q.last;
  end

  // ---------------------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------------------
  result_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] fifo_cnt_q;
  logic                  fifo_push, out_pop;
  result_t               head;

  assign fifo_push    = s4_q.emit;
  assign out_valid_o  = (fifo_cnt_q != '0);
  assign out_pop      = out_valid_o && !out_stall_i;
  assign head         = fifo_q[rd_ptr_q];
  assign result_ch0_o = head.res[0];
  assign result_ch1_o = head.res[1];
  assign result_ch2_o = head.res[2];
  assign frame_end_o  = head.frame_end;

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (emit && !out_pop) begin
      pend_d = pend_q + FIFO_CNT_W'(1);
    end else if (!emit && out_pop) begin
      pend_d = pend_q - FIFO_CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_bank_q  <= '0;
      in_done_q  <= 1'b0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_bank_q <= '0;
      pre_busy_q <= 1'b0;
      pre_col_q  <= '0;
      pre_last_q <= 1'b0;
      pend_q     <= '0;
      s1_q       <= '0;
      s2_q       <= '0;
      s3_q       <= '0;
      s4_q       <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      in_bank_q  <= in_bank_d;
      in_done_q  <= in_done_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_bank_q <= out_bank_d;
      pre_busy_q <= pre_busy_d;
      pre_col_q  <= pre_col_d;
      pre_last_q <= pre_last_d;
      pend_q     <= pend_d;
      s1_q       <= fetch_d;
      s2_q       <= '{valid: s1_q.valid, col_ok: s1_q.col_ok, clear: s1_q.clear,
                      emit: s1_q.emit, last: s1_q.last};
      s3_q       <= '{emit: s2_q.valid && s2_q.emit, last: s2_q.last};
      s4_q       <= s3_q;
      if (fifo_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (fifo_push && !out_pop) begin
        fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(1);
      end else if (!fifo_push && out_pop) begin
        fifo_cnt_q <= fifo_cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pre_mask_q <= pre_mask_d;
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_push && !out_pop && (fifo_cnt_q == FIFO_CNT_W'(FIFO_DEPTH))))
    else $error("output queue overflow");

  a_pend_covers_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q >= fifo_cnt_q)
    else $error("outstanding count below queue fill");

  a_inflight_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_q.emit |-> (pend_q > fifo_cnt_q))
    else $error("result in flight not counted as outstanding");

endmodule

`default_nettype wire
